### rtl/core/ulr_pkg.sv
// ----------------------------------------------------------------------------
// ulr_pkg: shared types and constants for the UART line receiver
// Receiver phases, the per-tick symbol handed from sampler to framer,
// the result record and the character codes used for line framing.
// ----------------------------------------------------------------------------
package ulr_pkg;

    // Receive buffer depth, a power of two
    localparam int BUFFER_DEPTH = 16384;

    localparam int IDX_W = 14;
    localparam int TPB_W = 16;

    localparam logic [IDX_W-1:0] IDX_MASK =
        (BUFFER_DEPTH >= (1 << IDX_W)) ? {IDX_W{1'b1}} : IDX_W'(BUFFER_DEPTH - 1);

    localparam logic [TPB_W-1:0] TPB_RESET = 16'd26;

    localparam logic [7:0] CH_CR = 8'h0d;
    localparam logic [7:0] CH_LF = 8'h0a;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HALF,
        PH_DATA,
        PH_STOP
    } rx_phase_t;

    // One record per accepted tick
    typedef struct packed {
        logic       byte_valid;
        logic [7:0] byte_value;
    } ulr_sym_t;

    typedef struct packed {
        logic             byte_valid;
        logic [7:0]       byte_value;
        logic [IDX_W-1:0] byte_index;
        logic             line_done;
        logic [IDX_W-1:0] line_length;
    } ulr_res_t;

endpackage

### rtl/core/uart_line_receiver_crlf_top.sv
// A tick's symbol passes the queue, then the output register, before its result leaves.
// Throughput: one tick per cycle without stalls; sampler and framer step once per cycle.
// The two-entry queue lets sampler and framer stall independently.
// Reset (rst_n low, asynchronous): receiver idle, counters and CR flag clear,
// ticks_per_bit back to 26, queue and output register empty.
// ----------------------------------------------------------------------------
// uart_line_receiver_crlf_top: UART 8N1 receiver with CR LF line framing
// One input transfer per oversampling tick, one result transfer per tick.
// ----------------------------------------------------------------------------
module uart_line_receiver_crlf_top
    import ulr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,     // ticks_per_bit
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,       // [0] rx_level, [7:1] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,       // [7:0] byte_value, [21:8] byte_index,
                                       // [35:22] line_length, [39:36] zero
    output logic [1:0]  m_tuser        // [0] byte_valid, [1] line_done
);

    logic     f_valid;
    ulr_sym_t f_sym;
    logic     f_ready;
    logic     q_valid;
    ulr_sym_t q_sym;
    logic     q_ready;
    ulr_res_t res;

    ulr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (s_tvalid),
        .in_level  (s_tdata[0]),
        .in_ready  (s_tready),
        .sym_valid (f_valid),
        .sym       (f_sym),
        .sym_ready (f_ready)
    );

    ulr_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (f_valid),
        .wr_data  (f_sym),
        .wr_ready (f_ready),
        .rd_valid (q_valid),
        .rd_data  (q_sym),
        .rd_ready (q_ready)
    );

    ulr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .sym_valid (q_valid),
        .sym       (q_sym),
        .sym_ready (q_ready),
        .res_valid (m_tvalid),
        .res       (res),
        .res_ready (m_tready)
    );

    assign m_tdata = {4'h0, res.line_length, res.byte_index, res.byte_value};
    assign m_tuser = {res.line_done, res.byte_valid};

endmodule

### rtl/core/ulr_front.sv
// ----------------------------------------------------------------------------
// ulr_front: 8N1 bit sampler
// Tracks start detection, start centering, data sampling and stop wait for
// each tick, and emits one symbol per tick that flags a completed byte.
// ----------------------------------------------------------------------------
module ulr_front
    import ulr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [TPB_W-1:0] cfg_wdata,
    input  logic             in_valid,
    input  logic             in_level,
    output logic             in_ready,
    output logic             sym_valid,
    output ulr_sym_t         sym,
    input  logic             sym_ready
);

    rx_phase_t        phase_reg, phase_next;
    logic [TPB_W-1:0] tpb_reg;
    logic [TPB_W-1:0] tick_reg, tick_next;
    logic [2:0]       bit_reg, bit_next;
    logic [7:0]       shift_reg, shift_next;

    logic [TPB_W-1:0] tick_inc;
    logic             half_done;
    logic             bit_done;
    logic [7:0]       sample_bits;
    logic             take;

    assign in_ready  = sym_ready;
    assign sym_valid = in_valid;
    assign take      = in_valid && sym_ready;

    assign tick_inc    = tick_reg + 16'd1;
    assign half_done   = tick_inc >= {1'b0, tpb_reg[TPB_W-1:1]};
    assign bit_done    = tick_inc >= tpb_reg;
    assign sample_bits = shift_reg | (8'(in_level) << bit_reg);

    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_IDLE: if (!in_level) phase_next = PH_HALF;
            PH_HALF: if (half_done) phase_next = PH_DATA;
            PH_DATA: if (bit_done && bit_reg == 3'd7) phase_next = PH_STOP;
            PH_STOP: if (in_level) phase_next = PH_IDLE;
            default: phase_next = PH_IDLE;
        endcase
    end

    always_comb
    begin
        tick_next      = tick_reg;
        bit_next       = bit_reg;
        shift_next     = shift_reg;
        sym.byte_valid = 1'b0;
        sym.byte_value = 8'h00;
        unique case (phase_reg)
            PH_IDLE:
            begin
                if (!in_level) tick_next = '0;
            end
            PH_HALF:
            begin
                tick_next = half_done ? '0 : tick_inc;
                if (half_done)
                begin
                    bit_next   = 3'd0;
                    shift_next = 8'h00;
                end
            end
            PH_DATA:
            begin
                tick_next = bit_done ? '0 : tick_inc;
                if (bit_done)
                begin
                    shift_next = sample_bits;
                    bit_next   = bit_reg + 3'd1;
                    if (bit_reg == 3'd7)
                    begin
                        sym.byte_valid = 1'b1;
                        sym.byte_value = sample_bits;
                    end
                end
            end
            PH_STOP:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            tpb_reg   <= TPB_RESET;
            tick_reg  <= '0;
            bit_reg   <= '0;
            shift_reg <= '0;
        end
        else
        begin
            if (cfg_we) tpb_reg <= cfg_wdata;
            if (take)
            begin
                phase_reg <= phase_next;
                tick_reg  <= tick_next;
                bit_reg   <= bit_next;
                shift_reg <= shift_next;
            end
        end
    end

endmodule

### rtl/core/ulr_queue.sv
// ----------------------------------------------------------------------------
// ulr_queue: two-entry symbol queue
// Decouples the bit sampler from the line framer so each side stalls alone.
// ----------------------------------------------------------------------------
module ulr_queue
    import ulr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     wr_valid,
    input  ulr_sym_t wr_data,
    output logic     wr_ready,
    output logic     rd_valid,
    output ulr_sym_t rd_data,
    input  logic     rd_ready
);

    ulr_sym_t   q_mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg, count_next;
    logic       push;
    logic       pop;

    assign wr_ready = count_reg != 2'd2;
    assign rd_valid = count_reg != 2'd0;
    assign rd_data  = q_mem[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop) count_next = count_reg + 2'd1;
        else if (pop && !push) count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (push) q_mem[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop) rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_next;
        end
    end

endmodule

### rtl/core/ulr_back.sv
// ----------------------------------------------------------------------------
// ulr_back: CR LF line framer
// Counts received bytes, tracks a seen carriage return, ends a line on a
// later line feed and holds each result in an output register.
// ----------------------------------------------------------------------------
module ulr_back
    import ulr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     sym_valid,
    input  ulr_sym_t sym,
    output logic     sym_ready,
    output logic     res_valid,
    output ulr_res_t res,
    input  logic     res_ready
);

    logic [IDX_W-1:0] count_reg, count_next;
    logic             cr_reg, cr_next;
    logic             out_valid_reg;
    ulr_res_t         res_reg, res_next;

    logic [IDX_W-1:0] count_inc;
    logic             line_end;
    logic             pop;

    assign pop       = sym_valid && (!out_valid_reg || res_ready);
    assign sym_ready = !out_valid_reg || res_ready;
    assign count_inc = count_reg + 14'd1;
    assign line_end  = sym.byte_value == CH_LF && cr_reg;

    always_comb
    begin
        count_next           = count_reg;
        cr_next              = cr_reg;
        res_next.byte_valid  = sym.byte_valid;
        res_next.byte_value  = sym.byte_valid ? sym.byte_value : 8'h00;
        res_next.byte_index  = sym.byte_valid ? (count_reg & IDX_MASK) : '0;
        res_next.line_done   = 1'b0;
        res_next.line_length = '0;
        if (sym.byte_valid)
        begin
            count_next = count_inc;
            if (sym.byte_value == CH_CR)
            begin
                cr_next = 1'b1;
            end
            else if (line_end)
            begin
                res_next.line_done   = 1'b1;
                res_next.line_length = count_inc - 14'd2;
                count_next           = '0;
                cr_next              = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop) res_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            cr_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                count_reg <= count_next;
                cr_reg    <= cr_next;
            end
            // hold the result until the transfer completes
            if (pop) out_valid_reg <= 1'b1;
            else if (res_ready) out_valid_reg <= 1'b0;
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = res_reg;

endmodule
